[hdl/date_difference_in_days_unit_defines.svh]
// Assertion macros shared by the date difference unit.
`ifndef DATE_DIFFERENCE_IN_DAYS_UNIT_DEFINES_SVH
`define DATE_DIFFERENCE_IN_DAYS_UNIT_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define DDD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent in the cycle after the antecedent.
`define DDD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ddd_pkg.sv]
// Package with the widths, types and tables of the date difference unit.
package ddd_pkg;

    localparam int DAY_W         = 5;
    localparam int MONTH_W       = 4;
    localparam int YEAR_W        = 14;
    localparam int DIST_W        = 23;
    localparam int ACC_W         = 23;
    localparam int DOY_W         = 9;
    localparam int SUM_W         = 25;
    localparam int DAYS_PER_YEAR = 365;
    localparam int GREG_CYCLE    = 400;
    localparam int CENTURY       = 100;
    localparam int DIST_MAX      = 4194303;
    localparam int DIST_MIN      = -4194304;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,
        S_SPAN,
        S_FINISH
    } t_ddd_state;

    typedef struct packed {
        logic load;
        logic reduce_step;
        logic span_step;
        logic finish;
    } t_ddd_cmd;

    typedef struct packed {
        logic reduce_done;
        logic span_done;
        logic out_full;
    } t_ddd_status;

    // Days in the months before the given one; month zero reads as January
    // and months past twelve read as December.
    function automatic logic [DOY_W-1:0] cum_days(input logic leap,
                                                  input logic [MONTH_W-1:0] month);
        logic [DOY_W-1:0] base;
        logic             feb_past;
        base     = '0;
        feb_past = 1'b1;
        case (month)
            4'd0, 4'd1: begin base = 9'd0;   feb_past = 1'b0; end
            4'd2:       begin base = 9'd31;  feb_past = 1'b0; end
            4'd3:       base = 9'd59;
            4'd4:       base = 9'd90;
            4'd5:       base = 9'd120;
            4'd6:       base = 9'd151;
            4'd7:       base = 9'd181;
            4'd8:       base = 9'd212;
            4'd9:       base = 9'd243;
            4'd10:      base = 9'd273;
            4'd11:      base = 9'd304;
            default:    base = 9'd334;
        endcase
        return base + DOY_W'(leap & feb_past);
    endfunction

endpackage

[hdl/ddd_in_if.sv]
// Input channel: the start and end dates of one query.
interface ddd_in_if import ddd_pkg::*;;
    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [YEAR_W-1:0]  start_year;
    logic [DAY_W-1:0]   end_day;
    logic [MONTH_W-1:0] end_month;
    logic [YEAR_W-1:0]  end_year;

    modport source (output valid, start_day, start_month, start_year,
                    end_day, end_month, end_year, input ready);
    modport sink   (input valid, start_day, start_month, start_year,
                    end_day, end_month, end_year, output ready);
endinterface

[hdl/ddd_out_if.sv]
// Output channel: the signed day distance of one query.
interface ddd_out_if import ddd_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DIST_W-1:0] day_distance;

    modport source (output valid, day_distance, input ready);
    modport sink   (input valid, day_distance, output ready);
endinterface

[hdl/ddd_ctrl.sv]
// Controller state machine sequencing load, reduction, year span and finish.
module ddd_ctrl import ddd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_ddd_status i_status,
    output t_ddd_cmd    o_cmd
);

    t_ddd_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (i_status.reduce_done) begin
                    n_state = S_SPAN;
                end else begin
                    o_cmd.reduce_step = 1'b1;
                end
            end
            S_SPAN: begin
                o_cmd.span_step = 1'b1;
                if (i_status.span_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // Hold until the output register is free.
                if (!i_status.out_full) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[hdl/ddd_dpath.sv]
// Datapath: year counter with leap tracking, span accumulator and result register.
module ddd_dpath import ddd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ddd_cmd                 i_cmd,
    output t_ddd_status              o_status,
    input  logic [DAY_W-1:0]         i_start_day,
    input  logic [MONTH_W-1:0]       i_start_month,
    input  logic [YEAR_W-1:0]        i_start_year,
    input  logic [DAY_W-1:0]         i_end_day,
    input  logic [MONTH_W-1:0]       i_end_month,
    input  logic [YEAR_W-1:0]        i_end_year,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic signed [DIST_W-1:0] o_day_distance
);

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(DIST_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(DIST_MIN);

    logic [DAY_W-1:0]   r_sd, r_ed;
    logic [MONTH_W-1:0] r_sm, r_em;
    logic [YEAR_W-1:0]  r_sy, r_ey;
    logic [YEAR_W-1:0]  r_year, r_hi, r_rem400;
    logic [ACC_W-1:0]   r_acc;
    logic               r_neg, r_leap_s, r_leap_e;
    logic               r_out_valid;
    logic signed [DIST_W-1:0] r_dist;

    logic                     w_leap;
    logic                     w_swap;
    logic [DOY_W-1:0]         w_doy_s, w_doy_e;
    logic signed [SUM_W-1:0]  w_span, w_total, w_sat;

    assign w_swap = i_end_year < i_start_year;

    // The year's position in the 400-year cycle settles the leap rule.
    assign w_leap = (r_rem400 == '0) ||
                    ((r_year[1:0] == 2'b00) &&
                     (r_rem400 != YEAR_W'(CENTURY)) &&
                     (r_rem400 != YEAR_W'(2 * CENTURY)) &&
                     (r_rem400 != YEAR_W'(3 * CENTURY)));

    assign w_doy_s = cum_days(r_leap_s, r_sm) + DOY_W'(r_sd);
    assign w_doy_e = cum_days(r_leap_e, r_em) + DOY_W'(r_ed);
    assign w_span  = r_neg ? -$signed({2'b00, r_acc}) : $signed({2'b00, r_acc});
    assign w_total = w_span + $signed(SUM_W'(w_doy_e)) - $signed(SUM_W'(w_doy_s));

    always_comb begin
        if (w_total > SAT_HI) begin
            w_sat = SAT_HI;
        end else if (w_total < SAT_LO) begin
            w_sat = SAT_LO;
        end else begin
            w_sat = w_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sd     <= i_start_day;
            r_sm     <= i_start_month;
            r_sy     <= i_start_year;
            r_ed     <= i_end_day;
            r_em     <= i_end_month;
            r_ey     <= i_end_year;
            r_neg    <= w_swap;
            r_year   <= w_swap ? i_end_year : i_start_year;
            r_rem400 <= w_swap ? i_end_year : i_start_year;
            r_hi     <= w_swap ? i_start_year : i_end_year;
            r_acc    <= '0;
        end
        if (i_cmd.reduce_step) begin
            r_rem400 <= r_rem400 - YEAR_W'(GREG_CYCLE);
        end
        if (i_cmd.span_step) begin
            if (r_year == r_sy) begin
                r_leap_s <= w_leap;
            end
            if (r_year == r_ey) begin
                r_leap_e <= w_leap;
            end
            if (r_year != r_hi) begin
                r_acc    <= r_acc + ACC_W'(DAYS_PER_YEAR) + ACC_W'(w_leap);
                r_year   <= r_year + YEAR_W'(1);
                r_rem400 <= (r_rem400 == YEAR_W'(GREG_CYCLE - 1)) ? '0
                                                                 : r_rem400 + YEAR_W'(1);
            end
        end
        if (i_cmd.finish) begin
            r_dist <= w_sat[DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.reduce_done = r_rem400 < YEAR_W'(GREG_CYCLE);
    assign o_status.span_done   = r_year == r_hi;
    assign o_status.out_full    = r_out_valid && !i_out_ready;
    assign o_out_valid          = r_out_valid;
    assign o_day_distance       = r_dist;

endmodule

[hdl/date_difference_in_days_unit.sv]
// Top level of the date difference unit: controller, datapath and checks.
//
//   port   | dir | fields
//   -------+-----+--------------------------------------------------------------
//   i_in   | in  | start_day, start_month, start_year, end_day, end_month, end_year
//   o_out  | out | day_distance (signed days from start to end, saturated)
//
// The year counter adds one year of the span per cycle, after the lower
// year is brought into the 400-year cycle by one subtraction per cycle.
// One item is in work at a time; a new item is taken once the last finished.
// A stalled output holds its result and the next one waits in the datapath.
// Reset is synchronous and clears only the controller and the output valid.
`include "date_difference_in_days_unit_defines.svh"

module date_difference_in_days_unit import ddd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    ddd_in_if.sink    i_in,
    ddd_out_if.source o_out
);

    t_ddd_cmd    w_cmd;
    t_ddd_status w_status;
    logic        w_in_ready;
    logic        w_out_valid;
    logic signed [DIST_W-1:0] w_dist;

    ddd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ddd_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_start_day    (i_in.start_day),
        .i_start_month  (i_in.start_month),
        .i_start_year   (i_in.start_year),
        .i_end_day      (i_in.end_day),
        .i_end_month    (i_in.end_month),
        .i_end_year     (i_in.end_year),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (w_out_valid),
        .o_day_distance (w_dist)
    );

    assign i_in.ready         = w_in_ready;
    assign o_out.valid        = w_out_valid;
    assign o_out.day_distance = w_dist;

    `DDD_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready, "input taken while an item is in work")
    `DDD_ASSERT_SAME(a_finish_free, i_clk, i_rst_n, w_cmd.finish, !(o_out.valid && !o_out.ready), "result written over a waiting one")
    `DDD_ASSERT_SAME(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0(w_cmd), "more than one datapath command")
    `DDD_ASSERT_NEXT(a_finish_valid, i_clk, i_rst_n, w_cmd.finish, o_out.valid, "finished item not shown")

endmodule

[dv/testbench.sv]
// Self-checking testbench for the date difference unit: directed and random date pairs.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ddd_pkg::*;

    localparam int MAX_YEAR = (1 << YEAR_W) - 1;
    localparam int MAX_DAY  = (1 << DAY_W) - 1;
    localparam int MAX_MON  = (1 << MONTH_W) - 1;
    localparam int MONTH_START [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    typedef struct packed {
        logic [DAY_W-1:0]   start_day;
        logic [MONTH_W-1:0] start_month;
        logic [YEAR_W-1:0]  start_year;
        logic [DAY_W-1:0]   end_day;
        logic [MONTH_W-1:0] end_month;
        logic [YEAR_W-1:0]  end_year;
    } t_date_pair;

    typedef struct packed {
        t_date_pair               dates;
        logic signed [DIST_W-1:0] distance;
    } t_pending_distance;

    logic i_clk;
    logic i_rst_n;

    ddd_in_if  in_if ();
    ddd_out_if out_if ();

    date_difference_in_days_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_pending_distance pending_distance_q[$];

    int     tx_idle_pct;
    int     rx_idle_pct;
    int     error_count;
    int     items_sent;
    int     results_checked;
    int     saturated_items;
    longint cycle_count;
    longint cycle_budget;
    int     longest_item_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Day count predictor
    // ------------------------------------------------------------------
    function automatic bit leap_year(input logic [YEAR_W-1:0] year);
        int unsigned y;
        y = year;
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    // Days in all the years from 0 up to, but not including, the given year.
    function automatic longint days_before(input logic [YEAR_W-1:0] year);
        longint n;
        n = longint'(year);
        return 365 * n + (n + 3) / 4 - (n + 99) / 100 + (n + 399) / 400;
    endfunction

    function automatic longint year_day(input logic [DAY_W-1:0] day,
                                        input logic [MONTH_W-1:0] month,
                                        input logic [YEAR_W-1:0] year);
        int m;
        m = month;
        if (m < 1) m = 1;
        if (m > 12) m = 12;
        return longint'(day) + MONTH_START[m-1] + ((leap_year(year) && m > 2) ? 1 : 0);
    endfunction

    function automatic logic signed [DIST_W-1:0] predict_day_distance(input t_date_pair p);
        longint span;
        span = days_before(p.end_year) - days_before(p.start_year)
             - year_day(p.start_day, p.start_month, p.start_year)
             + year_day(p.end_day, p.end_month, p.end_year);
        if (span > DIST_MAX) span = DIST_MAX;
        if (span < DIST_MIN) span = DIST_MIN;
        return span[DIST_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    task automatic send_dates(input int sd, input int sm, input int sy,
                              input int ed, input int em, input int ey);
        t_date_pair        p;
        t_pending_distance entry;
        int                span;
        int                est;
        p.start_day   = sd[DAY_W-1:0];
        p.start_month = sm[MONTH_W-1:0];
        p.start_year  = sy[YEAR_W-1:0];
        p.end_day     = ed[DAY_W-1:0];
        p.end_month   = em[MONTH_W-1:0];
        p.end_year    = ey[YEAR_W-1:0];
        if ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.start_day   <= p.start_day;
        in_if.start_month <= p.start_month;
        in_if.start_year  <= p.start_year;
        in_if.end_day     <= p.end_day;
        in_if.end_month   <= p.end_month;
        in_if.end_year    <= p.end_year;
        do @(posedge i_clk); while (!in_if.ready);
        entry.dates    = p;
        entry.distance = predict_day_distance(p);
        pending_distance_q.push_back(entry);
        items_sent++;
        if (entry.distance == DIST_W'(DIST_MAX) || entry.distance == DIST_W'(DIST_MIN))
            saturated_items++;
        // The block walks one year of the span per cycle, plus the 400-year reduction.
        span = (p.end_year > p.start_year) ? p.end_year - p.start_year
                                           : p.start_year - p.end_year;
        est  = span + ((p.end_year < p.start_year) ? p.end_year : p.start_year) / 400 + 4;
        if (est > longest_item_cycles) longest_item_cycles = est;
        cycle_budget += 4 * est + 400;
    endtask

    task automatic wait_for_results();
        in_if.valid <= 1'b0;
        while (pending_distance_q.size() > 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result checker and receiver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pending_distance exp_item;
        cycle_count++;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_distance_q.size() == 0) begin
                if (error_count < 10)
                    $display("ERROR: result %0d arrived with no item pending",
                             $signed(out_if.day_distance));
                error_count++;
            end else begin
                exp_item = pending_distance_q.pop_front();
                results_checked++;
                if (out_if.day_distance !== exp_item.distance) begin
                    if (error_count < 10)
                        $display("ERROR: %0d/%0d/%0d -> %0d/%0d/%0d expected %0d, got %0d",
                                 exp_item.dates.start_day, exp_item.dates.start_month,
                                 exp_item.dates.start_year, exp_item.dates.end_day,
                                 exp_item.dates.end_month, exp_item.dates.end_year,
                                 $signed(exp_item.distance), $signed(out_if.day_distance));
                    error_count++;
                end
            end
        end
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin
        wait (cycle_budget > 0);
        while (cycle_count <= cycle_budget) @(posedge i_clk);
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, pending_distance_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_field_extremes();
        send_dates(0, 0, 0, 0, 0, 0);
        send_dates(MAX_DAY, MAX_MON, MAX_YEAR, MAX_DAY, MAX_MON, MAX_YEAR);
        send_dates(1, 1, 1, 31, 12, 9999);
        send_dates(31, 12, 9999, 1, 1, 1);
        // Spans this wide overflow the result field and must clamp.
        send_dates(0, 0, 0, MAX_DAY, MAX_MON, MAX_YEAR);
        send_dates(MAX_DAY, MAX_MON, MAX_YEAR, 0, 0, 0);
    endtask

    task automatic test_leap_rules();
        send_dates(28, 2, 1900, 1, 3, 1900);
        send_dates(28, 2, 2000, 1, 3, 2000);
        send_dates(28, 2, 2024, 1, 3, 2024);
        send_dates(28, 2, 2023, 1, 3, 2023);
        send_dates(28, 2, 2100, 1, 3, 2100);
        send_dates(28, 2, 2400, 1, 3, 2400);
        send_dates(28, 2, 0, 1, 3, 0);
        send_dates(31, 12, 1999, 1, 1, 2000);
        send_dates(1, 1, 1896, 1, 1, 1904);
        send_dates(15, 6, 2001, 15, 6, 1601);
    endtask

    task automatic test_month_and_day_edges();
        send_dates(10, 0, 2020, 10, 1, 2020);
        send_dates(5, 13, 2020, 5, 12, 2020);
        send_dates(1, 15, 2024, 1, 0, 2025);
        send_dates(0, 3, 2019, 31, 2, 2019);
        send_dates(31, 4, 2021, 0, 5, 2021);
        send_dates(7, 7, 2007, 7, 7, 2007);
    endtask

    task automatic random_dates(input bit wide_span);
        int sy, ey, sd, ed, sm, em;
        sy = $urandom_range(MAX_YEAR);
        if (wide_span) begin
            ey = $urandom_range(MAX_YEAR);
        end else begin
            ey = sy + $urandom_range(40) - 20;
            if (ey < 0) ey = 0;
            if (ey > MAX_YEAR) ey = MAX_YEAR;
        end
        sd = ($urandom_range(99) < 85) ? $urandom_range(31, 1) : $urandom_range(MAX_DAY);
        ed = ($urandom_range(99) < 85) ? $urandom_range(31, 1) : $urandom_range(MAX_DAY);
        sm = ($urandom_range(99) < 85) ? $urandom_range(12, 1) : $urandom_range(MAX_MON);
        em = ($urandom_range(99) < 85) ? $urandom_range(12, 1) : $urandom_range(MAX_MON);
        send_dates(sd, sm, sy, ed, em, ey);
    endtask

    task automatic test_random_dates(input int count, input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count) random_dates($urandom_range(19) == 0);
    endtask

    // The sender holds off here until the block has handed back everything.
    task automatic test_pause_until_drained();
        repeat (3) random_dates(1'b0);
        wait_for_results();
        repeat (3) random_dates(1'b0);
    endtask

    initial begin
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.start_day     = '0;
        in_if.start_month   = '0;
        in_if.start_year    = '0;
        in_if.end_day       = '0;
        in_if.end_month     = '0;
        in_if.end_year      = '0;
        out_if.ready        = 1'b0;
        tx_idle_pct         = 8;
        rx_idle_pct         = 52;
        error_count         = 0;
        items_sent          = 0;
        results_checked     = 0;
        saturated_items     = 0;
        cycle_count         = 0;
        cycle_budget        = 20000;
        longest_item_cycles = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_leap_rules();
        test_month_and_day_edges();
        test_random_dates(24, 8, 52);
        test_pause_until_drained();
        test_random_dates(23, 52, 8);
        test_random_dates(23, 0, 0);

        wait_for_results();
        repeat (longest_item_cycles + 32) @(posedge i_clk);

        $display("Checked %0d of %0d date pairs: field extremes, leap rules, month and day edges,",
                 results_checked, items_sent);
        $display("%0d clamped spans and random dates under three idle mixes.", saturated_items);
        if (error_count == 0 && pending_distance_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d results missing", error_count,
                     pending_distance_q.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

[date_difference_in_days_unit.f]
+incdir+hdl
hdl/ddd_pkg.sv
hdl/ddd_in_if.sv
hdl/ddd_out_if.sv
hdl/ddd_ctrl.sv
hdl/ddd_dpath.sv
hdl/date_difference_in_days_unit.sv
dv/testbench.sv
